// ===== hw/rtl/avb_pkg.sv =====
// shared types and constants for the avcc to annex b converter
package avb_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned SIZE_W   = 3;
    localparam int unsigned SPS_LEN_W = 16;

    localparam logic [7:0] VIDEO_TAG     = 8'h09;
    localparam logic [7:0] CODEC_MASK    = 8'h0f;
    localparam logic [7:0] CODEC_AVC     = 8'h07;
    localparam logic [7:0] SIZE_MASK     = 8'h03;
    localparam logic [7:0] PKT_CONFIG    = 8'h00;
    localparam logic [7:0] PKT_NALU      = 8'h01;
    localparam logic [7:0] PKT_EOS       = 8'h02;
    localparam logic [1:0] KIND_NALU     = 2'd1;
    localparam logic [1:0] KIND_OTHER    = 2'd3;

    localparam logic [POS_W-1:0] POS_CTIME    = 5'd2;
    localparam logic [POS_W-1:0] POS_CFG      = 5'd5;
    localparam logic [POS_W-1:0] POS_SIZE     = 5'd9;
    localparam logic [POS_W-1:0] POS_SPS_LEN  = 5'd11;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;
    localparam logic [1:0] SC_LAST_BEAT = 2'd3;

    // one queued output event: a whole start code or one copied byte
    typedef struct packed {
        logic             sc;
        logic [BYTE_W-1:0] data;
    } t_desc;

endpackage

// ===== hw/rtl/avb_in_if.sv =====
// input channel: flv tag body bytes
interface avb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] tag_type;
    logic [7:0] body_byte;
    logic       tag_end;

    modport source (output valid, output tag_type, output body_byte, output tag_end,
                    input ready);
    modport sink   (input valid, input tag_type, input body_byte, input tag_end,
                    output ready);
endinterface

// ===== hw/rtl/avb_out_if.sv =====
// output channel: annex b byte stream
interface avb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       unit_start;
    logic       run_last;

    modport source (output valid, output out_byte, output unit_start, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input unit_start, input run_last,
                    output ready);
endinterface

// ===== hw/rtl/avb_parse.sv =====
// tag body parser: walks the flv/avc header and nal length prefixes
module avb_parse #(
    parameter int unsigned MAX_PREFIX_BYTES = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_room,
    input  logic [7:0]     i_tag_type,
    input  logic [7:0]     i_body_byte,
    input  logic           i_tag_end,
    output logic           o_ready,
    output logic           o_push,
    output avb_pkg::t_desc o_desc
);

    typedef enum logic [3:0] {
        PH_HEAD, PH_TYPE, PH_CTIME, PH_PREFIX, PH_PAYLOAD, PH_CFG, PH_SPSLEN,
        PH_SPS, PH_PPSNUM, PH_PPSLEN, PH_PPS, PH_IDLE
    } t_phase;

    localparam logic [avb_pkg::SIZE_W-1:0] MAX_SIZE = avb_pkg::SIZE_W'(MAX_PREFIX_BYTES);

    t_phase                          r_phase, n_phase;
    logic [avb_pkg::POS_W-1:0]       r_pos, n_pos;
    logic [avb_pkg::SIZE_W-1:0]      r_size, n_size;
    logic [avb_pkg::SIZE_W-1:0]      r_seen, n_seen;
    logic [avb_pkg::LEN_W-1:0]       r_acc, n_acc;
    logic [avb_pkg::LEN_W-1:0]       r_left, n_left;
    logic [1:0]                      r_kind, n_kind;

    logic                            accept;
    logic [avb_pkg::LEN_W-1:0]       acc_shift;
    logic [avb_pkg::LEN_W-1:0]       left_dec;
    logic [avb_pkg::SIZE_W-1:0]      seen_inc;
    logic [avb_pkg::POS_W-1:0]       pos_inc;
    logic [avb_pkg::SIZE_W-1:0]      cfg_size;
    logic                            emit;
    logic                            emit_sc;

    assign o_ready   = i_room;
    assign accept    = i_valid && i_room;
    assign acc_shift = {r_acc[avb_pkg::LEN_W-9:0], i_body_byte};
    assign left_dec  = r_left - avb_pkg::LEN_W'(1);
    assign seen_inc  = r_seen + avb_pkg::SIZE_W'(1);
    assign pos_inc   = r_pos + avb_pkg::POS_W'(1);
    // size field is 1..4, clipped to what the build supports
    assign cfg_size  = (avb_pkg::SIZE_W'(i_body_byte[1:0]) + avb_pkg::SIZE_W'(1) > MAX_SIZE)
                       ? MAX_SIZE
                       : avb_pkg::SIZE_W'(i_body_byte[1:0]) + avb_pkg::SIZE_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_size  = r_size;
        n_seen  = r_seen;
        n_acc   = r_acc;
        n_left  = r_left;
        n_kind  = r_kind;
        emit    = 1'b0;
        emit_sc = 1'b0;
        case (r_phase)
            PH_HEAD: begin
                if (i_tag_type == avb_pkg::VIDEO_TAG &&
                    (i_body_byte & avb_pkg::CODEC_MASK) == avb_pkg::CODEC_AVC) begin
                    n_phase = PH_TYPE;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_TYPE: begin
                n_kind = (i_body_byte > avb_pkg::PKT_EOS) ? avb_pkg::KIND_OTHER
                                                         : i_body_byte[1:0];
                if (i_body_byte == avb_pkg::PKT_CONFIG || i_body_byte == avb_pkg::PKT_NALU) begin
                    n_phase = PH_CTIME;
                    n_pos   = avb_pkg::POS_CTIME;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_CTIME: begin
                n_pos = pos_inc;
                if (pos_inc >= avb_pkg::POS_CFG) begin
                    n_seen  = '0;
                    n_acc   = '0;
                    n_phase = (r_kind == avb_pkg::KIND_NALU) ? PH_PREFIX : PH_CFG;
                end
            end
            PH_PREFIX: begin
                n_acc  = acc_shift;
                n_seen = seen_inc;
                if (seen_inc >= r_size) begin
                    emit    = 1'b1;
                    emit_sc = 1'b1;
                    n_left  = acc_shift;
                    n_acc   = '0;
                    n_seen  = '0;
                    n_phase = (acc_shift != '0) ? PH_PAYLOAD : PH_PREFIX;
                end
            end
            PH_PAYLOAD: begin
                emit   = 1'b1;
                n_left = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_PREFIX;
                end
            end
            PH_CFG: begin
                if (r_pos == avb_pkg::POS_SIZE) begin
                    n_size = cfg_size;
                end
                n_pos = pos_inc;
                if (pos_inc >= avb_pkg::POS_SPS_LEN) begin
                    n_seen  = '0;
                    n_acc   = '0;
                    n_phase = PH_SPSLEN;
                end
            end
            PH_SPSLEN, PH_PPSLEN: begin
                // parameter set lengths are always two bytes
                n_acc  = {{(avb_pkg::LEN_W-avb_pkg::SPS_LEN_W){1'b0}},
                          acc_shift[avb_pkg::SPS_LEN_W-1:0]};
                n_seen = seen_inc;
                if (seen_inc >= avb_pkg::SIZE_W'(2)) begin
                    emit    = 1'b1;
                    emit_sc = 1'b1;
                    n_left  = {{(avb_pkg::LEN_W-avb_pkg::SPS_LEN_W){1'b0}},
                               acc_shift[avb_pkg::SPS_LEN_W-1:0]};
                    n_acc   = '0;
                    n_seen  = '0;
                    if (acc_shift[avb_pkg::SPS_LEN_W-1:0] != '0) begin
                        n_phase = (r_phase == PH_SPSLEN) ? PH_SPS : PH_PPS;
                    end else begin
                        n_phase = (r_phase == PH_SPSLEN) ? PH_PPSNUM : PH_IDLE;
                    end
                end
            end
            PH_SPS, PH_PPS: begin
                emit   = 1'b1;
                n_left = left_dec;
                if (left_dec == '0) begin
                    n_phase = (r_phase == PH_SPS) ? PH_PPSNUM : PH_IDLE;
                end
            end
            PH_PPSNUM: begin
                n_seen  = '0;
                n_acc   = '0;
                n_phase = PH_PPSLEN;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        // tag end drops all parse state but the prefix size
        if (i_tag_end) begin
            n_phase = PH_HEAD;
            n_pos   = '0;
            n_seen  = '0;
            n_acc   = '0;
            n_left  = '0;
            n_kind  = '0;
        end
    end

    assign o_push      = accept && emit;
    assign o_desc.sc   = emit_sc;
    assign o_desc.data = i_body_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_pos   <= '0;
            r_size  <= MAX_SIZE;
            r_seen  <= '0;
            r_acc   <= '0;
            r_left  <= '0;
            r_kind  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_size  <= n_size;
            r_seen  <= n_seen;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_kind  <= n_kind;
        end
    end

endmodule

// ===== hw/rtl/avb_outq.sv =====
// two-entry event queue and byte serialiser for the annex b output
module avb_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  avb_pkg::t_desc i_desc,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_byte,
    output logic           o_unit_start,
    output logic           o_run_last
);

    avb_pkg::t_desc r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           r_cur_valid;
    avb_pkg::t_desc r_cur;
    logic [1:0]     r_beat;

    logic last_beat;
    logic advance;
    logic pop;
    logic do_push;

    assign o_room    = (r_cnt != 2'd2);
    assign do_push   = i_push && o_room;
    assign last_beat = !r_cur.sc || (r_beat == avb_pkg::SC_LAST_BEAT);
    assign advance   = !r_cur_valid || (i_ready && last_beat);
    assign pop       = advance && (r_cnt != 2'd0);

    assign o_valid      = r_cur_valid;
    assign o_byte       = !r_cur.sc ? r_cur.data
                        : (r_beat == avb_pkg::SC_LAST_BEAT) ? avb_pkg::SC_ONE
                        : avb_pkg::SC_ZERO;
    assign o_unit_start = r_cur.sc && (r_beat == 2'd0);
    assign o_run_last   = last_beat;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_desc;
        end
        if (pop) begin
            r_cur <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= 1'b0;
            r_rp        <= 1'b0;
            r_cnt       <= 2'd0;
            r_cur_valid <= 1'b0;
            r_beat      <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(pop);
            if (advance) begin
                r_cur_valid <= pop;
                r_beat      <= 2'd0;
            end else if (i_ready) begin
                r_beat <= r_beat + 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/avcc_to_annexb_converter.sv =====
// top level: flv avc tag body to h.264 annex b byte stream
// Takes one tag body byte per cycle and turns video tags carrying codec 7 into an
// Annex B stream. A NALU packet gives a start code (00 00 00 01, unit_start on the
// first 00) after each length prefix, then the copied payload; a configuration
// packet sets the prefix size and gives the first SPS and first PPS the same way.
// Each body byte is parsed in the cycle it is taken, so input runs at one byte per
// cycle while the output keeps up; a start code is four output bytes, and the
// two-entry event queue in front of the output register stalls input while it
// drains. Each result passes through the event queue and then the output register.
module avcc_to_annexb_converter #(
    parameter int unsigned MAX_PREFIX_BYTES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    avb_in_if.sink     i_in,
    avb_out_if.source  o_out
);

    logic           room;
    logic           push;
    avb_pkg::t_desc desc;

    avb_parse #(
        .MAX_PREFIX_BYTES (MAX_PREFIX_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_room      (room),
        .i_tag_type  (i_in.tag_type),
        .i_body_byte (i_in.body_byte),
        .i_tag_end   (i_in.tag_end),
        .o_ready     (i_in.ready),
        .o_push      (push),
        .o_desc      (desc)
    );

    avb_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_desc       (desc),
        .o_room       (room),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_byte       (o_out.out_byte),
        .o_unit_start (o_out.unit_start),
        .o_run_last   (o_out.run_last)
    );

endmodule
